@@ rtl/core/keyed_infix_expression_evaluator_core_assert.svh @@
// Assertion macros for the expression evaluator core.
// Each macro expects clk and arst_n in the scope of use.
`ifndef KEYED_INFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define KEYED_INFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define KIEE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kiee assertion failed");
`define KIEE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kiee assertion failed");
`else
`define KIEE_ASSERT_NOW(lbl, ante, cons)
`define KIEE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/kiee_pkg.sv @@
package kiee_pkg;
	localparam int VALUE_BITS        = 48;
	localparam int FRACTION_BITS_DEF = 16;

	// key actions
	localparam logic [2:0] ACT_DIGIT = 3'd0;
	localparam logic [2:0] ACT_ADD   = 3'd1;
	localparam logic [2:0] ACT_SUB   = 3'd2;
	localparam logic [2:0] ACT_MUL   = 3'd3;
	localparam logic [2:0] ACT_DIV   = 3'd4;
	localparam logic [2:0] ACT_EQ    = 3'd5;
	localparam logic [2:0] ACT_CLR   = 3'd6;

	// operator codes on the stack
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_MALF = 2'd2;
	localparam logic [1:0] ST_OVF  = 2'd3;

	localparam logic [3:0] DIGIT_MAX = 4'd9;

	typedef struct packed {
		logic [2:0] action;
		logic [3:0] digit;
	} key_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] result_value;
		logic [1:0]                   status;
	} res_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_DECODE,
		CS_CHECK,
		CS_RUN,
		CS_EMIT
	} ctrl_state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_DIGIT,
		CMD_MALF,
		CMD_PUSH_NUM,
		CMD_PUSH_OP,
		CMD_RED_START,
		CMD_RED_WB,
		CMD_EMIT,
		CMD_CLEAR
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t cmd;
	} dp_ctrl_t;

	typedef struct packed {
		logic [2:0] action;
		logic       frozen;
		logic       started;
		logic [1:0] val_count;
		logic [1:0] op_count;
		logic       top_high;
		logic       new_high;
		logic       unit_done;
		logic       unit_busy;
		logic       out_free;
	} dp_stat_t;
endpackage

@@ rtl/core/kiee_arith.sv @@
module kiee_arith #(
	parameter int FRACTION_BITS = kiee_pkg::FRACTION_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [1:0]                            op,
	input  logic signed [kiee_pkg::VALUE_BITS-1:0] a,
	input  logic signed [kiee_pkg::VALUE_BITS-1:0] b,
	output logic                                  done,
	output logic                                  busy,
	output logic                                  ovf,
	output logic                                  divz,
	output logic signed [kiee_pkg::VALUE_BITS-1:0] result
);
	import kiee_pkg::*;

	localparam int W  = VALUE_BITS;
	localparam int NW = W + FRACTION_BITS;
	localparam int XW = 2 * W + FRACTION_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [1:0]            op_q;
	logic                  neg_q;
	logic signed [W-1:0]   sa_q, sb_q;
	logic [W-1:0]          ma_q, mb_q;
	logic [W:0]            hi_q;
	logic [W-1:0]          lo_q;
	logic [W:0]            r_q;
	logic [NW-1:0]         n_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q, done_q, divz_q;

	logic [W-1:0] ma_c, mb_c;
	logic [W:0]   msum, rs;
	logic         ge;

	assign ma_c = a[W-1] ? (~a + 1'b1) : a;
	assign mb_c = b[W-1] ? (~b + 1'b1) : b;

	// shift-add multiply step and restoring divide step
	assign msum = hi_q + {1'b0, (lo_q[0] ? ma_q : {W{1'b0}})};
	assign rs   = {r_q[W-1:0], n_q[NW-1]};
	assign ge   = rs >= {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (op == OP_ADD || op == OP_SUB || (op == OP_DIV && mb_c == '0)) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q && cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= op;
			neg_q  <= a[W-1] ^ b[W-1];
			sa_q   <= a;
			sb_q   <= b;
			ma_q   <= ma_c;
			mb_q   <= mb_c;
			divz_q <= (op == OP_DIV) && (mb_c == '0);
			hi_q   <= '0;
			lo_q   <= mb_c;
			r_q    <= '0;
			n_q    <= NW'(ma_c) << FRACTION_BITS;
			cnt_q  <= (op == OP_MUL) ? CW'(W) : CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (op_q == OP_MUL) begin
				hi_q <= msum >> 1;
				lo_q <= {msum[0], lo_q[W-1:1]};
			end else begin
				r_q <= ge ? (rs - {1'b0, mb_q}) : rs;
				n_q <= {n_q[NW-2:0], ge};
			end
		end
	end

	// saturation of the unsigned magnitude, and saturated add/sub
	logic [2*W-1:0] prod;
	logic [XW-1:0]  mag, lim;
	logic           neg, over;
	logic [W-1:0]   md;
	logic signed [W:0] as_sum;
	logic           as_ov;
	logic signed [W-1:0] as_res, md_res;
	logic           is_as;

	always_comb begin
		prod   = {hi_q[W-1:0], lo_q};
		mag    = (op_q == OP_MUL) ? XW'(prod >> FRACTION_BITS) : XW'(n_q);
		neg    = neg_q && (mag != '0);
		lim    = neg ? (XW'(1) << (W - 1)) : ((XW'(1) << (W - 1)) - 1'b1);
		over   = mag > lim;
		md     = over ? lim[W-1:0] : mag[W-1:0];
		md_res = neg ? -$signed(md) : $signed(md);
		is_as  = (op_q == OP_ADD) || (op_q == OP_SUB);
		as_sum = (op_q == OP_SUB) ? ({sa_q[W-1], sa_q} - {sb_q[W-1], sb_q})
		                          : ({sa_q[W-1], sa_q} + {sb_q[W-1], sb_q});
		as_ov  = as_sum[W] ^ as_sum[W-1];
		if (as_ov) begin
			as_res = as_sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			as_res = as_sum[W-1:0];
		end
	end

	assign done   = done_q;
	assign busy   = busy_q;
	assign divz   = divz_q;
	assign ovf    = is_as ? as_ov : (over && !divz_q);
	assign result = divz_q ? '0 : (is_as ? as_res : md_res);
endmodule

@@ rtl/core/kiee_ctrl.sv @@
module kiee_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               key_valid,
	input  kiee_pkg::dp_stat_t stat,
	output logic               key_stall,
	output kiee_pkg::dp_ctrl_t ctl
);
	import kiee_pkg::*;

	ctrl_state_t state_q, state_n;
	logic is_eq, want_red;

	assign is_eq    = stat.action == ACT_EQ;
	assign want_red = (stat.op_count != 2'd0) && (is_eq || stat.top_high || !stat.new_high);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (key_valid) state_n = CS_DECODE;
			end
			CS_DECODE: begin
				case (stat.action)
					ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
						state_n = (stat.frozen || !stat.started) ? CS_IDLE : CS_CHECK;
					end
					ACT_EQ: begin
						state_n = (stat.frozen || !stat.started) ? CS_EMIT : CS_CHECK;
					end
					default: state_n = CS_IDLE;
				endcase
			end
			CS_CHECK: begin
				if (stat.frozen) begin
					state_n = is_eq ? CS_EMIT : CS_IDLE;
				end else if (want_red) begin
					if (stat.val_count >= 2'd2) state_n = CS_RUN;
				end else begin
					state_n = is_eq ? CS_EMIT : CS_IDLE;
				end
			end
			CS_RUN: begin
				if (stat.unit_done) state_n = CS_CHECK;
			end
			CS_EMIT: begin
				if (stat.out_free) state_n = CS_IDLE;
			end
			default: state_n = CS_IDLE;
		endcase
	end

	always_comb begin
		ctl.cmd   = CMD_NONE;
		key_stall = 1'b1;
		unique case (state_q)
			CS_IDLE: begin
				key_stall = 1'b0;
				if (key_valid) ctl.cmd = CMD_LATCH;
			end
			CS_DECODE: begin
				case (stat.action)
					ACT_DIGIT: ctl.cmd = CMD_DIGIT;
					ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_EQ: begin
						if (!stat.frozen) ctl.cmd = stat.started ? CMD_PUSH_NUM : CMD_MALF;
					end
					ACT_CLR: ctl.cmd = CMD_CLEAR;
					default: ctl.cmd = CMD_NONE;
				endcase
			end
			CS_CHECK: begin
				if (!stat.frozen) begin
					if (want_red) begin
						ctl.cmd = (stat.val_count >= 2'd2) ? CMD_RED_START : CMD_MALF;
					end else if (!is_eq) begin
						ctl.cmd = CMD_PUSH_OP;
					end
				end
			end
			CS_RUN: begin
				if (stat.unit_done) ctl.cmd = CMD_RED_WB;
			end
			CS_EMIT: begin
				if (stat.out_free) ctl.cmd = CMD_EMIT;
			end
			default: ctl.cmd = CMD_NONE;
		endcase
	end
endmodule

@@ rtl/core/kiee_dpath.sv @@
module kiee_dpath #(
	parameter int FRACTION_BITS = kiee_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kiee_pkg::key_t     key,
	input  kiee_pkg::dp_ctrl_t ctl,
	input  logic               res_stall,
	output kiee_pkg::dp_stat_t stat,
	output logic               res_valid,
	output kiee_pkg::res_t     res
);
	import kiee_pkg::*;

	localparam int W  = VALUE_BITS;
	localparam int DW = W + FRACTION_BITS + 5;

	logic [2:0]          act_q;
	logic [3:0]          dig_q;
	logic [W-1:0]        pend_q;
	logic                started_q;
	logic signed [W-1:0] vs_q [3];  // [0] is the top
	logic [1:0]          vc_q;
	logic [1:0]          os_q [2];  // [0] is the top
	logic [1:0]          oc_q;
	logic [1:0]          err_q;
	logic                res_valid_q;
	res_t                res_q;

	logic frozen;
	logic [1:0] err_malf, err_ovf, opc;
	logic [DW-1:0] ext, acc, maxv;
	logic dov;
	logic [W-1:0] pend_n;
	logic signed [W-1:0] top_val;

	logic a_done, a_busy, a_ovf, a_divz;
	logic signed [W-1:0] a_res;

	assign frozen   = (err_q == ST_DIVZ) || (err_q == ST_MALF);
	assign err_malf = frozen ? err_q : ST_MALF;
	assign err_ovf  = (err_q == ST_OK) ? ST_OVF : err_q;
	assign opc      = 2'(act_q - ACT_ADD);

	// pending = pending * 10 + digit, saturated
	assign ext    = DW'(pend_q);
	assign acc    = (ext << 3) + (ext << 1) + (DW'(dig_q) << FRACTION_BITS);
	assign maxv   = (DW'(1) << (W - 1)) - 1'b1;
	assign dov    = acc > maxv;
	assign pend_n = dov ? maxv[W-1:0] : acc[W-1:0];

	assign top_val = (!frozen && vc_q != 2'd0) ? vs_q[0] : '0;

	kiee_arith #(.FRACTION_BITS(FRACTION_BITS)) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.cmd == CMD_RED_START),
		.op     (os_q[0]),
		.a      (vs_q[1]),
		.b      (vs_q[0]),
		.done   (a_done),
		.busy   (a_busy),
		.ovf    (a_ovf),
		.divz   (a_divz),
		.result (a_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			started_q   <= 1'b0;
			vc_q        <= 2'd0;
			oc_q        <= 2'd0;
			err_q       <= ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.cmd == CMD_EMIT) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (ctl.cmd)
				CMD_DIGIT: begin
					if (!frozen) begin
						if (dig_q > DIGIT_MAX) begin
							err_q <= err_malf;
						end else begin
							pend_q    <= pend_n;
							started_q <= 1'b1;
							if (dov) err_q <= err_ovf;
						end
					end
				end
				CMD_MALF: err_q <= err_malf;
				CMD_PUSH_NUM: begin
					if (vc_q < 2'd3) begin
						vc_q <= vc_q + 1'b1;
					end else begin
						err_q <= err_malf;
					end
					pend_q    <= '0;
					started_q <= 1'b0;
				end
				CMD_PUSH_OP: begin
					if (oc_q < 2'd2) begin
						oc_q <= oc_q + 1'b1;
					end else begin
						err_q <= err_malf;
					end
				end
				CMD_RED_WB: begin
					vc_q <= vc_q - 1'b1;
					oc_q <= oc_q - 1'b1;
					if (a_divz) begin
						err_q <= err_malf == ST_MALF ? ST_DIVZ : err_q;
					end else if (a_ovf) begin
						err_q <= err_ovf;
					end
				end
				CMD_EMIT, CMD_CLEAR: begin
					pend_q    <= '0;
					started_q <= 1'b0;
					vc_q      <= 2'd0;
					oc_q      <= 2'd0;
					err_q     <= ST_OK;
				end
				default: ;
			endcase
		end
	end

	// payload: latched key, stacks, result register
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_LATCH: begin
				act_q <= key.action;
				dig_q <= key.digit;
			end
			CMD_PUSH_NUM: begin
				if (vc_q < 2'd3) begin
					vs_q[2] <= vs_q[1];
					vs_q[1] <= vs_q[0];
					vs_q[0] <= $signed(pend_q);
				end
			end
			CMD_PUSH_OP: begin
				if (oc_q < 2'd2) begin
					os_q[1] <= os_q[0];
					os_q[0] <= opc;
				end
			end
			CMD_RED_WB: begin
				vs_q[0] <= a_res;
				vs_q[1] <= vs_q[2];
				os_q[0] <= os_q[1];
			end
			CMD_EMIT: begin
				res_q.result_value <= top_val;
				res_q.status       <= err_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.action    = act_q;
		stat.frozen    = frozen;
		stat.started   = started_q;
		stat.val_count = vc_q;
		stat.op_count  = oc_q;
		stat.top_high  = os_q[0][1];
		stat.new_high  = opc[1];
		stat.unit_done = a_done;
		stat.unit_busy = a_busy;
		stat.out_free  = !res_valid_q || !res_stall;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule

@@ rtl/core/keyed_infix_expression_evaluator_core.sv @@
// Sequence: digit and clear keys are decoded and applied, an operator also
//   goes through a check and each reduction; add/sub reductions are computed
//   directly, multiply and divide one bit per cycle in the shared arith unit.
// Throughput: one key at a time; the next key is taken once the last is done.
// Equals writes a result register and frees the input side at once.
// Reset: arst_n clears counts, flags, state and result valid; no clearing pass.
`include "keyed_infix_expression_evaluator_core_assert.svh"
module keyed_infix_expression_evaluator_core #(
	parameter int FRACTION_BITS = kiee_pkg::FRACTION_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           key_valid,
	output logic           key_stall,
	input  kiee_pkg::key_t key,
	output logic           res_valid,
	input  logic           res_stall,
	output kiee_pkg::res_t res
);
	import kiee_pkg::*;

	// controller to datapath commands, datapath to controller status
	dp_ctrl_t ctl;
	dp_stat_t stat;

	// sequencer: decode key, push number, reduce loop, push operator or emit
	kiee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.stat      (stat),
		.key_stall (key_stall),
		.ctl       (ctl)
	);

	// stacks, pending number, error status, serial mul/div, result register
	kiee_dpath #(.FRACTION_BITS(FRACTION_BITS)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key),
		.ctl       (ctl),
		.res_stall (res_stall),
		.stat      (stat),
		.res_valid (res_valid),
		.res       (res)
	);

	// a reduction needs two values and one operator on the stacks
	`KIEE_ASSERT_NOW(a_red_operands, ctl.cmd == CMD_RED_START, stat.val_count >= 2'd2 && stat.op_count != 2'd0)
	// keys are never taken while the arith unit is working
	`KIEE_ASSERT_NOW(a_idle_unit, !key_stall, !stat.unit_busy)
	// a started reduction holds off the input side
	`KIEE_ASSERT_NEXT(a_red_stall, ctl.cmd == CMD_RED_START, key_stall)
endmodule
